### rtl/core/huf_pkg.sv
`default_nettype none

package huf_pkg;

  // alphabet size sets the node table and the pending stack
  localparam int ALPHABET = 256;
  localparam int NODES    = 2 * ALPHABET - 1;

  localparam int SYM_W  = 8;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int LVL_W  = $clog2(ALPHABET + 1);
  localparam int STK_AW = $clog2(ALPHABET);

  // commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_BIT   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SYMBOL = 2'd0;
  localparam logic [1:0] ST_LOADED = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  // one node: the left child of an internal node is always the next node
  // in preorder, so only the right child index is kept
  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] right;
  } node_t;

endpackage

`default_nettype wire

### rtl/core/huffman_preorder_tree_decoder.sv
`default_nettype none

// huffman decoder with a tree loaded as a preorder shape string
//
// command channel: a word (cmd, bit_value, leaf_symbol) is taken on a rising
// edge with start high and busy low. cmd clear empties the tree, cmd mark
// appends one preorder node (1 internal, 0 leaf with leaf_symbol), cmd bit
// steps the walk left on 0 or right on 1.
// result channel: strobe is high for exactly one cycle per result word;
// status gives symbol decoded, tree load complete or error, and
// decoded_symbol carries the symbol for a decode, else zero. the receiver
// cannot stall, so results are never held back.
// results are registered: one appears in the cycle after its command is
// taken, but for a code bit that descends into the tree the node table read
// and then S_WALK lie between. busy: clear, errors and most marks leave it
// low; a mark that closes a right child holds it through S_PARENT (stack
// read, then the parent's table write), a descending code bit through
// S_WALK (one read of the node table per tree level). the root node is
// mirrored in a register, so a bit on a one-leaf tree leaves busy low.
// reset: the tree is empty, the walk sits at the root, no result is pending.
// the node table and the stack need no clearing: the walk only runs over a
// complete tree, whose nodes have all been written.

module huffman_preorder_tree_decoder (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  wire  [1:0]               cmd,
  input  wire                      bit_value,
  input  wire  [huf_pkg::SYM_W-1:0] leaf_symbol,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic [huf_pkg::SYM_W-1:0] decoded_symbol
);
  import huf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PARENT,
    S_WALK
  } state_t;

  state_t state;

  // tree load state
  logic [CNT_W-1:0]  node_count;
  logic [LVL_W-1:0]  stack_level;
  logic              tree_complete;
  logic              prev_leaf;
  logic [NODE_W-1:0] pend_node;

  // walk state
  logic [NODE_W-1:0] walk_node;
  logic [NODE_W-1:0] next_node;
  node_t             root_entry;
  node_t             cur_entry;

  // memories
  node_t             node_mem [NODES];
  logic [NODE_W-1:0] stack_mem [ALPHABET];
  node_t             node_rd;
  logic [NODE_W-1:0] stack_rd;

  logic              node_we;
  logic [NODE_W-1:0] node_waddr;
  node_t             node_wdata;
  logic [NODE_W-1:0] node_raddr;
  logic              stack_we;
  logic [STK_AW-1:0] stack_waddr;

  // decode of the incoming word
  logic              accept;
  logic              as_right;
  logic              mark_err;
  logic [LVL_W-1:0]  lvl_pop;
  logic [LVL_W-1:0]  lvl_after;
  node_t             cur_node;
  node_t             new_node;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    // a node after a leaf becomes the right child of the stack top
    as_right  = (node_count != '0) && prev_leaf;
    lvl_pop   = stack_level - LVL_W'(1);
    mark_err  = tree_complete || (node_count == CNT_W'(NODES))
                || (bit_value && (stack_level == LVL_W'(ALPHABET)))
                || (as_right && (stack_level == '0));
    lvl_after = as_right ? lvl_pop : stack_level;

    new_node.leaf  = !bit_value;
    new_node.sym   = bit_value ? '0 : leaf_symbol;
    new_node.right = '0;

    // root lives in a register so the walk never waits on it
    cur_node   = (walk_node == '0) ? root_entry : cur_entry;
    node_raddr = bit_value ? cur_node.right : walk_node + NODE_W'(1);
  end

  always_comb begin
    node_we     = 1'b0;
    node_waddr  = node_count[NODE_W-1:0];
    node_wdata  = new_node;
    stack_we    = 1'b0;
    stack_waddr = as_right ? lvl_pop[STK_AW-1:0] : stack_level[STK_AW-1:0];
    if (state == S_PARENT) begin
      node_we          = 1'b1;
      node_waddr       = stack_rd;
      node_wdata.leaf  = 1'b0;
      node_wdata.sym   = '0;
      node_wdata.right = pend_node;
    end else if (accept && (cmd == CMD_MARK) && !mark_err) begin
      node_we  = 1'b1;
      stack_we = bit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd <= node_mem[node_raddr];
  end

  // read-first: a pop and push at the same slot still returns the old top
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= node_count[NODE_W-1:0];
    end
    stack_rd <= stack_mem[lvl_pop[STK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      node_count     <= '0;
      stack_level    <= '0;
      tree_complete  <= 1'b0;
      prev_leaf      <= 1'b0;
      walk_node      <= '0;
      strobe         <= 1'b0;
      status         <= ST_SYMBOL;
      decoded_symbol <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_CLEAR: begin
                node_count    <= '0;
                stack_level   <= '0;
                tree_complete <= 1'b0;
                walk_node     <= '0;
              end
              CMD_MARK: begin
                if (mark_err) begin
                  strobe         <= 1'b1;
                  status         <= ST_ERROR;
                  decoded_symbol <= '0;
                end else begin
                  node_count <= node_count + CNT_W'(1);
                  prev_leaf  <= !bit_value;
                  pend_node  <= node_count[NODE_W-1:0];
                  if (node_count == '0) begin
                    root_entry <= new_node;
                  end
                  if (bit_value) begin
                    stack_level <= lvl_after + LVL_W'(1);
                  end else begin
                    stack_level <= lvl_after;
                  end
                  if (as_right) begin
                    state <= S_PARENT;
                  end
                  if (!bit_value && (lvl_after == '0)) begin
                    tree_complete  <= 1'b1;
                    walk_node      <= '0;
                    strobe         <= 1'b1;
                    status         <= ST_LOADED;
                    decoded_symbol <= '0;
                  end
                end
              end
              CMD_BIT: begin
                if (!tree_complete) begin
                  strobe         <= 1'b1;
                  status         <= ST_ERROR;
                  decoded_symbol <= '0;
                end else if (cur_node.leaf) begin
                  // one-leaf tree: every bit gives the root symbol
                  walk_node      <= '0;
                  strobe         <= 1'b1;
                  status         <= ST_SYMBOL;
                  decoded_symbol <= cur_node.sym;
                end else begin
                  next_node <= node_raddr;
                  state     <= S_WALK;
                end
              end
              default: begin
                strobe         <= 1'b1;
                status         <= ST_ERROR;
                decoded_symbol <= '0;
              end
            endcase
          end
        end
        S_PARENT: begin
          if (stack_rd == '0) begin
            root_entry.right <= pend_node;
          end
          state <= S_IDLE;
        end
        S_WALK: begin
          if (node_rd.leaf) begin
            walk_node      <= '0;
            strobe         <= 1'b1;
            status         <= ST_SYMBOL;
            decoded_symbol <= node_rd.sym;
          end else begin
            walk_node <= next_node;
            cur_entry <= node_rd;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_cycle_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (state == S_IDLE))
    else $error("busy lasted more than one extra cycle");

  a_symbol_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status != ST_SYMBOL)) |-> (decoded_symbol == '0))
    else $error("symbol driven on a non-decode result");

  a_loaded_complete: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_LOADED)) |-> tree_complete)
    else $error("load complete reported on an incomplete tree");

  a_complete_stack_empty: assert property (@(posedge clk) disable iff (rst)
    tree_complete |-> (stack_level == '0))
    else $error("complete tree with pending internal nodes");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (stack_level <= LVL_W'(ALPHABET)) && (node_count <= CNT_W'(NODES)))
    else $error("stack level or node count out of range");
`endif

endmodule

`default_nettype wire
